// ===== hdl/patan_pkg.sv =====
// patan_pkg: shared types, fixed-point constants and rounding helpers
// for the polynomial atan2 pipeline. No dependencies.
package patan_pkg;

    // Ratio format: unsigned, 16 fraction bits, 0 .. 1.0 inclusive
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_W    = RATIO_FRAC + 1;

    // Signed working word for polynomial terms (Q16) and its product width
    localparam int TERM_W = 18;
    localparam int PROD_W = 2 * TERM_W;

    // Width of the angle field on the output port
    localparam int ANGLE_W = 16;

    typedef logic signed [TERM_W-1:0] t_q16;
    typedef logic signed [PROD_W-1:0] t_prod;

    // Octant and quadrant flags that ride along with each beat
    typedef struct packed {
        logic oct;   // |y| > |x|: reflect about pi/2
        logic xneg;  // x < 0: reflect about pi
        logic yneg;  // y < 0: negate
    } t_side;

    // Polynomial coefficients in Q16
    localparam t_q16 COEF_C3 = -18'sd3047;
    localparam t_q16 COEF_C2 = 18'sd10441;
    localparam t_q16 COEF_C1 = 18'sd21471;

    // pi with 60 fraction bits
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Signed Q16 x Q16 multiply, full product
    function automatic t_prod mul_q16(input t_q16 a, input t_q16 b);
        t_prod ea;
        t_prod eb;
        ea = PROD_W'(a);
        eb = PROD_W'(b);
        return ea * eb;
    endfunction

    // Drop 16 fraction bits, round to nearest, ties away from zero
    function automatic t_q16 rnd_q16(input t_prod p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] m;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        m   = (mag + (PROD_W'(1) << (RATIO_FRAC - 1))) >> RATIO_FRAC;
        return p[PROD_W-1] ? -$signed(m[TERM_W-1:0]) : $signed(m[TERM_W-1:0]);
    endfunction

endpackage

// ===== hdl/patan_div.sv =====
// patan_div: pipelined restoring divider, one quotient bit per stage.
// Produces floor(small * 2^16 / large), zero when large is zero.
// Depends on patan_pkg.
module patan_div #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [COORD_BITS-1:0]             i_small,
    input  logic [COORD_BITS-1:0]             i_large,
    input  patan_pkg::t_side                  i_side,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [patan_pkg::RATIO_W-1:0]     o_ratio,
    output patan_pkg::t_side                  o_side
);

    localparam int NS = patan_pkg::RATIO_W;

    logic [NS-1:0]            r_v;
    logic [COORD_BITS-1:0]    r_rem   [NS];
    logic [COORD_BITS-1:0]    r_large [NS];
    logic [NS-1:0]            r_q     [NS];
    patan_pkg::t_side         r_side  [NS];

    logic [NS:0]              en;
    logic [NS-1:0]            n_v;
    logic [COORD_BITS:0]      trial   [NS];
    logic [COORD_BITS:0]      diff    [NS];
    logic [COORD_BITS-1:0]    lg      [NS];
    logic [NS-1:0]            q_in    [NS];
    logic [NS-1:0]            ge;
    logic [COORD_BITS-1:0]    n_rem   [NS];
    logic [NS-1:0]            n_q     [NS];
    patan_pkg::t_side         n_side  [NS];

    // A stage moves when it is empty or the one after it moves
    always_comb begin
        en[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // One compare-subtract per stage; MSB of the quotient comes first
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                trial[k]  = {1'b0, i_small};
                lg[k]     = i_large;
                q_in[k]   = '0;
                n_v[k]    = i_valid;
                n_side[k] = i_side;
            end else begin
                trial[k]  = {r_rem[k-1], 1'b0};
                lg[k]     = r_large[k-1];
                q_in[k]   = r_q[k-1];
                n_v[k]    = r_v[k-1];
                n_side[k] = r_side[k-1];
            end
            diff[k]  = trial[k] - {1'b0, lg[k]};
            ge[k]    = trial[k] >= {1'b0, lg[k]};
            n_rem[k] = ge[k] ? diff[k][COORD_BITS-1:0] : trial[k][COORD_BITS-1:0];
            // zero divisor: quotient bits forced low
            n_q[k]   = {q_in[k][NS-2:0], ge[k] && (lg[k] != '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_rem[k]   <= n_rem[k];
                r_large[k] <= lg[k];
                r_q[k]     <= n_q[k];
                r_side[k]  <= n_side[k];
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];
    assign o_ratio = r_q[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== hdl/patan_poly.sv =====
// patan_poly: five-stage pipeline for r + r^3*(-c1 + r^2*(c2 + r^2*c3)),
// one multiply and rounding per stage, Q16 throughout.
// Depends on patan_pkg.
module patan_poly (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [patan_pkg::RATIO_W-1:0]     i_ratio,
    input  patan_pkg::t_side                  i_side,
    output logic                              o_valid,
    input  logic                              i_stall,
    output patan_pkg::t_q16                   o_atan,
    output patan_pkg::t_side                  o_side
);

    localparam int NS = 5;
    localparam int RW = patan_pkg::RATIO_W;

    logic [NS-1:0]       r_v;
    logic [NS-1:0]       n_v;
    logic [NS:0]         en;
    patan_pkg::t_side    r_side [NS];

    logic [RW-1:0]       r0_r, r0_sq;
    logic [RW-1:0]       r1_r, r1_sq;
    patan_pkg::t_q16     r1_t;
    logic [RW-1:0]       r2_r, r2_sq;
    patan_pkg::t_q16     r2_t;
    logic [RW-1:0]       r3_r;
    patan_pkg::t_q16     r3_t;
    patan_pkg::t_q16     r4_a;

    patan_pkg::t_q16     n0_sq, n1_t, n2_t, n3_t, n4_a;

    // Ready chain, same rule as the divider
    always_comb begin
        en[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // Valid bit each stage would take: input valid, then the stage before
    assign n_v = {r_v[NS-2:0], i_valid};

    // Stage arithmetic: multiply, round, then the coefficient or r add where the stage has one
    always_comb begin
        n0_sq = patan_pkg::rnd_q16(patan_pkg::mul_q16($signed({1'b0, i_ratio}),
                                                      $signed({1'b0, i_ratio})));
        n1_t  = patan_pkg::rnd_q16(patan_pkg::mul_q16(patan_pkg::COEF_C3,
                                                      $signed({1'b0, r0_sq})))
                + patan_pkg::COEF_C2;
        n2_t  = patan_pkg::rnd_q16(patan_pkg::mul_q16(r1_t, $signed({1'b0, r1_sq})))
                - patan_pkg::COEF_C1;
        n3_t  = patan_pkg::rnd_q16(patan_pkg::mul_q16(r2_t, $signed({1'b0, r2_sq})));
        n4_a  = patan_pkg::rnd_q16(patan_pkg::mul_q16(r3_t, $signed({1'b0, r3_r})))
                + $signed({1'b0, r3_r});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_r      <= i_ratio;
            r0_sq     <= n0_sq[RW-1:0];
            r_side[0] <= i_side;
        end
        if (en[1]) begin
            r1_r      <= r0_r;
            r1_sq     <= r0_sq;
            r1_t      <= n1_t;
            r_side[1] <= r_side[0];
        end
        if (en[2]) begin
            r2_r      <= r1_r;
            r2_sq     <= r1_sq;
            r2_t      <= n2_t;
            r_side[2] <= r_side[1];
        end
        if (en[3]) begin
            r3_r      <= r2_r;
            r3_t      <= n3_t;
            r_side[3] <= r_side[2];
        end
        if (en[4]) begin
            r4_a      <= n4_a;
            r_side[4] <= r_side[3];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];
    assign o_atan  = r4_a;
    assign o_side  = r_side[NS-1];

endmodule

// ===== hdl/polynomial_atan2_top.sv =====
// polynomial_atan2_top: four-quadrant atan2 with a degree-7 polynomial.
// Stages: magnitude/swap, divider, polynomial, then convert/octant and reflect.
// Throughput: one beat per cycle while the output is not stalled; the
// 17-stage bit-per-stage divider and the 5-stage multiply chain are fully
// pipelined. Stages with no beat fill up behind a stalled output. Reset clears
// only the stage valid bits. Depends on patan_pkg, patan_div, patan_poly.
module polynomial_atan2_top #(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_BITS-1:0]          i_coord_x,
    input  logic signed [COORD_BITS-1:0]          i_coord_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [patan_pkg::ANGLE_W-1:0]  o_angle
);

    localparam int PF     = patan_pkg::RATIO_FRAC;
    localparam int W_W    = (ANGLE_FRAC_BITS > PF ? ANGLE_FRAC_BITS : PF) + 4;
    localparam int SH_UP  = (ANGLE_FRAC_BITS >= PF) ? ANGLE_FRAC_BITS - PF : 0;
    localparam int SH_DN  = (ANGLE_FRAC_BITS < PF) ? PF - ANGLE_FRAC_BITS : 0;
    localparam int HALF_DN = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;

    // pi and pi/2 rounded to nearest at the output scale
    localparam logic [63:0] PI_RND =
        (patan_pkg::PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HPI_RND =
        (patan_pkg::PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
    localparam logic signed [W_W-1:0] PI_W  = $signed(PI_RND[W_W-1:0]);
    localparam logic signed [W_W-1:0] HPI_W = $signed(HPI_RND[W_W-1:0]);

    // ---- stage 0: magnitudes, order, flags
    logic                        r_v0;
    logic [COORD_BITS-1:0]       r_small, r_large;
    patan_pkg::t_side            r_side0;
    logic                        en0;
    logic [COORD_BITS:0]         neg_x, neg_y;
    logic [COORD_BITS-1:0]       ax, ay;
    patan_pkg::t_side            n_side0;

    logic                        div_stall, div_valid;
    logic [patan_pkg::RATIO_W-1:0] div_ratio;
    patan_pkg::t_side            div_side;

    logic                        poly_stall, poly_valid;
    patan_pkg::t_q16             poly_atan;
    patan_pkg::t_side            poly_side;

    // ---- convert/octant stage and reflect stage
    logic                        r_vc, r_vr;
    logic signed [W_W-1:0]       r_ac;
    patan_pkg::t_side            r_side_c;
    logic signed [patan_pkg::ANGLE_W-1:0] r_angle;
    logic                        en_c, en_r;
    logic signed [W_W-1:0]       conv_sum, conv, n_ac, refl, n_full;

    assign en_r    = !r_vr || !i_stall;
    assign en_c    = !r_vc || en_r;
    assign en0     = !r_v0 || !div_stall;
    assign o_stall = !en0;

    // Negation is one bit wider and the magnitude unsigned, so the most negative input is exact
    always_comb begin
        neg_x = -{i_coord_x[COORD_BITS-1], i_coord_x};
        neg_y = -{i_coord_y[COORD_BITS-1], i_coord_y};
        ax    = i_coord_x[COORD_BITS-1] ? neg_x[COORD_BITS-1:0] : i_coord_x;
        ay    = i_coord_y[COORD_BITS-1] ? neg_y[COORD_BITS-1:0] : i_coord_y;
        n_side0.oct  = ay > ax;
        n_side0.xneg = i_coord_x[COORD_BITS-1];
        n_side0.yneg = i_coord_y[COORD_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en0) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_small <= n_side0.oct ? ax : ay;
            r_large <= n_side0.oct ? ay : ax;
            r_side0 <= n_side0;
        end
    end

    patan_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .o_stall (div_stall),
        .i_small (r_small),
        .i_large (r_large),
        .i_side  (r_side0),
        .o_valid (div_valid),
        .i_stall (poly_stall),
        .o_ratio (div_ratio),
        .o_side  (div_side)
    );

    patan_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_stall (poly_stall),
        .i_ratio (div_ratio),
        .i_side  (div_side),
        .o_valid (poly_valid),
        .i_stall (!en_c),
        .o_atan  (poly_atan),
        .o_side  (poly_side)
    );

    // Rescale Q16 to the output fraction bits (value is never negative),
    // then fold the octant about pi/2
    always_comb begin
        conv_sum = W_W'(poly_atan) + W_W'(HALF_DN);
        conv     = (conv_sum >>> SH_DN) <<< SH_UP;
        n_ac     = poly_side.oct ? HPI_W - conv : conv;
    end

    // Quadrant fold: about pi for negative x, then sign for negative y
    always_comb begin
        refl   = r_side_c.xneg ? PI_W - r_ac : r_ac;
        n_full = r_side_c.yneg ? -refl : refl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vr <= 1'b0;
        end else begin
            if (en_c) begin
                r_vc <= poly_valid;
            end
            if (en_r) begin
                r_vr <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_ac     <= n_ac;
            r_side_c <= poly_side;
        end
        if (en_r) begin
            r_angle <= n_full[patan_pkg::ANGLE_W-1:0];
        end
    end

    assign o_valid = r_vr;
    assign o_angle = r_angle;

endmodule

// ===== verif/tb_polynomial_atan2_top.sv =====
// tb_polynomial_atan2_top: self-checking bench for the fixed-point atan2 pipeline.
// Directed table plus random points, with a bit-exact angle predictor and random stalls.
// Depends on patan_pkg and polynomial_atan2_top.
module tb_polynomial_atan2_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = 16;
    localparam int ANG_FRAC   = 13;
    localparam int POLY_Q     = 16;
    localparam int N_RANDOM   = 850;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_LEN   = 120;
    localparam int LIMIT_CYC  = 400000;
    localparam int DRAIN_CYC  = 40;

    // Polynomial coefficients in Q16 and pi with 60 fraction bits
    localparam longint K3    = -3047;
    localparam longint K2    = 10441;
    localparam longint K1    = 21471;
    localparam longint PI_60 = 64'h3243F6A8885A308D;

    typedef logic signed [COORD_W-1:0]            t_coord;
    typedef logic signed [patan_pkg::ANGLE_W-1:0] t_angle;

    // One row of the directed table; known rows carry a typed-in angle
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   known;
        t_angle ang;
    } t_row;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_angle ang;
    } t_pending;

    localparam int N_DIR = 24;
    localparam t_row DIR_TAB [N_DIR] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'sd0},       // origin
        '{16'sd5,      16'sd0,      1'b1, 16'sd0},
        '{-16'sd5,     16'sd0,      1'b1, 16'sd25736},   // negative x axis: +pi
        '{16'sd0,      16'sd5,      1'b1, 16'sd12868},
        '{16'sd0,      -16'sd5,     1'b1, -16'sd12868},
        '{-16'sd32768, 16'sd0,      1'b1, 16'sd25736},   // most negative x
        '{16'sd0,      -16'sd32768, 1'b1, -16'sd12868},  // most negative y
        '{16'sd32767,  16'sd0,      1'b1, 16'sd0},
        '{-16'sd1,     16'sd0,      1'b1, 16'sd25736},
        '{16'sd0,      16'sd1,      1'b1, 16'sd12868},
        '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},       // ratio exactly one
        '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
        '{16'sd1,      16'sd1,      1'b0, 16'sd0},
        '{-16'sd1,     16'sd1,      1'b0, 16'sd0},
        '{16'sd1,      -16'sd1,     1'b0, 16'sd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
        '{16'sd32767,  16'sd1,      1'b0, 16'sd0},
        '{16'sd1,      16'sd32767,  1'b0, 16'sd0},
        '{-16'sd32768, -16'sd1,     1'b0, 16'sd0},
        '{16'sd100,    -16'sd3,     1'b0, 16'sd0},
        '{-16'sd7,     16'sd12345,  1'b0, 16'sd0},
        '{-16'sd32768, -16'sd32767, 1'b0, 16'sd0}
    };

    localparam int N_TOTAL = N_DIR + N_RANDOM;
    localparam int HOLD_AT = N_DIR + 10;

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   i_valid   = 1'b0;
    logic   i_stall   = 1'b0;
    t_coord i_coord_x = '0;
    t_coord i_coord_y = '0;
    logic   o_stall;
    logic   o_valid;
    t_angle o_angle;

    // Side channel that rides with the input beat: typed-in angle, if any
    logic   cur_known = 1'b0;
    t_angle cur_ang   = '0;

    t_pending angle_q[$];
    int       n_in    = 0;
    int       n_err   = 0;
    longint   n_cycle = 0;

    polynomial_atan2_top #(
        .COORD_BITS      (COORD_W),
        .ANGLE_FRAC_BITS (ANG_FRAC)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_angle   (o_angle)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shift right by n, round to nearest, ties away from zero
    function automatic longint round_away(input longint v, input int n);
        longint half;
        if (n == 0) return v;
        half = longint'(1) << (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    // Expected angle of one point, bit for bit
    function automatic t_angle atan2_fix(input t_coord x, input t_coord y);
        longint ax, ay, lo, hi, r, sq, t, a, pi_f, hpi_f;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        lo = (ax < ay) ? ax : ay;
        hi = (ax < ay) ? ay : ax;
        r  = (hi == 0) ? 0 : (lo << POLY_Q) / hi;
        // odd polynomial r + r^3 * (-c1 + r^2 * (c2 + r^2 * c3))
        sq = round_away(r * r, POLY_Q);
        t  = round_away(K3 * sq, POLY_Q) + K2;
        t  = round_away(t * sq, POLY_Q) - K1;
        t  = round_away(t * sq, POLY_Q);
        t  = round_away(t * r, POLY_Q);
        a  = t + r;
        if (ANG_FRAC >= POLY_Q) a = a << (ANG_FRAC - POLY_Q);
        else a = round_away(a, POLY_Q - ANG_FRAC);
        pi_f  = round_away(PI_60, 60 - ANG_FRAC);
        hpi_f = round_away(PI_60, 61 - ANG_FRAC);
        // octant, then left half-plane, then lower half-plane
        if (ay > ax) a = hpi_f - a;
        if (x < 0) a = pi_f - a;
        if (y < 0) a = -a;
        return t_angle'(a);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0d: %s", n_cycle, what);
        n_err++;
    endtask

    // Output check against the oldest expectation, then capture of accepted input beats
    always @(posedge i_clk) begin : angle_mon
        t_pending e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (angle_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected angle %0d", o_angle));
                end else begin
                    e = angle_q.pop_front();
                    if (o_angle !== e.ang)
                        report_mismatch($sformatf("x=%0d y=%0d angle %0d, want %0d",
                                                  e.x, e.y, o_angle, e.ang));
                end
            end
            if (i_valid && !o_stall) begin
                e.x   = i_coord_x;
                e.y   = i_coord_y;
                e.ang = cur_known ? cur_ang : atan2_fix(i_coord_x, i_coord_y);
                angle_q.push_back(e);
                n_in <= n_in + 1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycle++;
        if (n_cycle >= LIMIT_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: one long hold-off to back the pipe up, then random stall bursts
    initial begin : rx_side
        int  n;
        bit  held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && n_in >= HOLD_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                for (n = 0; n < HOLD_LEN; n++) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!(n_in >= HOLD_AT + 330 && n_in < HOLD_AT + 420)
                         && n_in < N_TOTAL - TAIL_LEN && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 18);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Present one beat, optionally after an idle burst, and wait until it is taken
    task automatic send_point(input t_coord x, input t_coord y, input logic known,
                              input t_angle ang, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        cur_known <= known;
        cur_ang   <= ang;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Random point, biased toward diagonals, axes, extremes and tiny values
    task automatic pick_point(output t_coord x, output t_coord y);
        int d;
        x = t_coord'($urandom());
        y = t_coord'($urandom());
        d = $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 7))
            0: begin
                x = t_coord'(int'($urandom_range(0, 32)) - 16);
                y = t_coord'(int'($urandom_range(0, 32)) - 16);
            end
            1: y = t_coord'(int'(x) + d);
            2: y = t_coord'(-int'(x) + d);
            3: if ($urandom_range(0, 1)) x = '0; else y = '0;
            4: x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            5: y = t_coord'(int'($urandom_range(0, 64)) - 32);
            default: ;
        endcase
    endtask

    initial begin : stim
        t_coord x;
        t_coord y;
        bit     idle_ok;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        for (int i = 0; i < N_DIR; i++)
            send_point(DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].known, DIR_TAB[i].ang, 1'b1);

        // Random points; sender keeps offering through the hold-off and in calm spans
        for (int i = 0; i < N_RANDOM; i++) begin
            pick_point(x, y);
            idle_ok = !(i < 80 || (i >= 330 && i < 420) || i >= N_RANDOM - TAIL_LEN);
            send_point(x, y, 1'b0, '0, idle_ok);
        end

        // Last beat was taken at this edge: drop valid right away
        i_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (angle_q.size() != 0)
            report_mismatch($sformatf("%0d angles never arrived", angle_q.size()));

        if (n_err == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
